>>> sv/assert_macros.svh
// Assertion macros shared by the piece queue RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Clocked property, switched off while reset is asserted
`define PQRS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("pqrs assertion failed");
// Clocked property that also holds through reset
`define PQRS_ASSERT_NORST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) else $error("pqrs assertion failed");
`else
`define PQRS_ASSERT(lbl, clk, rstn, prop)
`define PQRS_ASSERT_NORST(lbl, clk, prop)
`endif
`endif

>>> sv/pqrs_pkg.sv
// Shared types and codes for the piece queue with reserve stack
`default_nettype none

package pqrs_pkg;

    // pieces traded by the triple swap
    localparam int TRIPLE = 3;

    localparam int KIND_W    = 3;
    localparam int TYPE_W    = 2;
    localparam int STATUS_W  = 3;
    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 3;

    // command kinds
    localparam logic [KIND_W-1:0] KIND_INSERT  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PLAY    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RESERVE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_USE     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SWAP1   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_SWAP3   = 3'd5;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 3'd0,
        STAT_QFULL  = 3'd1,
        STAT_QEMPTY = 3'd2,
        STAT_SFULL  = 3'd3,
        STAT_SEMPTY = 3'd4,
        STAT_TRIPLE = 3'd5
    } status_t;

    // datapath operations
    typedef enum logic [2:0] {
        OP_NONE,
        OP_INSERT,
        OP_PLAY,
        OP_RESERVE,
        OP_USE,
        OP_SWAP
    } op_t;

    // controller to datapath
    typedef struct packed {
        logic    accept;
        logic    rd;
        op_t     op;
        logic    step;
        logic    reject;
        status_t code;
        logic    out_load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              q_empty;
        logic              s_empty;
        logic              q_lt3;
        logic              s_lt3;
    } dp_stat_t;

endpackage

`default_nettype wire

>>> sv/pqrs_ctrl.sv
// Command sequencer of the piece queue with reserve stack
`default_nettype none

module pqrs_ctrl
    import pqrs_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire logic     m_ready,
    output logic          m_valid,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_READ,
        ST_XFER,
        ST_DONE
    } state_t;

    localparam logic [1:0] ITER_LAST = 2'(TRIPLE - 1);

    state_t     state_reg, state_next;
    logic [1:0] iter_reg, iter_next;
    logic       m_valid_reg, m_valid_next;

    // decode state into datapath commands
    always_comb begin
        cmd          = '0;
        cmd.op       = OP_NONE;
        cmd.code     = STAT_OK;
        state_next   = state_reg;
        iter_next    = iter_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    iter_next  = '0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                // read front and top while the checks settle
                cmd.rd     = 1'b1;
                state_next = ST_DONE;
                case (stat.kind)
                    KIND_INSERT: begin
                        cmd.op = OP_INSERT;
                    end
                    KIND_PLAY, KIND_RESERVE: begin
                        if (stat.q_empty) begin
                            cmd.reject = 1'b1;
                            cmd.code   = STAT_QEMPTY;
                        end else begin
                            state_next = ST_XFER;
                        end
                    end
                    KIND_USE: begin
                        if (stat.s_empty) begin
                            cmd.reject = 1'b1;
                            cmd.code   = STAT_SEMPTY;
                        end else begin
                            state_next = ST_XFER;
                        end
                    end
                    KIND_SWAP1: begin
                        if (stat.q_empty) begin
                            cmd.reject = 1'b1;
                            cmd.code   = STAT_QEMPTY;
                        end else if (stat.s_empty) begin
                            cmd.reject = 1'b1;
                            cmd.code   = STAT_SEMPTY;
                        end else begin
                            state_next = ST_XFER;
                        end
                    end
                    KIND_SWAP3: begin
                        if (stat.q_lt3 || stat.s_lt3) begin
                            cmd.reject = 1'b1;
                            cmd.code   = STAT_TRIPLE;
                        end else begin
                            state_next = ST_XFER;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_READ: begin
                cmd.rd     = 1'b1;
                state_next = ST_XFER;
            end
            ST_XFER: begin
                state_next = ST_DONE;
                case (stat.kind)
                    KIND_PLAY:    cmd.op = OP_PLAY;
                    KIND_RESERVE: cmd.op = OP_RESERVE;
                    KIND_USE:     cmd.op = OP_USE;
                    KIND_SWAP1:   cmd.op = OP_SWAP;
                    KIND_SWAP3: begin
                        // walk three queue and stack positions
                        cmd.op = OP_SWAP;
                        if (iter_reg != ITER_LAST) begin
                            cmd.step   = 1'b1;
                            iter_next  = iter_reg + 2'd1;
                            state_next = ST_READ;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            iter_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            iter_reg    <= iter_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

>>> sv/pqrs_dp.sv
// Datapath of the piece queue: stores, pointers, counters and result register
`default_nettype none
`include "assert_macros.svh"

module pqrs_dp
    import pqrs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8,
    parameter int STACK_DEPTH = 3,
    parameter int ID_WIDTH    = 16,
    parameter int M_TDATA_W   = 32
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [KIND_W-1:0]    in_kind,
    input  wire logic [TYPE_W-1:0]    in_type,
    input  wire dp_cmd_t              cmd,
    output dp_stat_t                  stat,
    output logic [M_TDATA_W-1:0]      out_data
);

    localparam int QA  = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam int SA  = $clog2(STACK_DEPTH);
    localparam int SCW = $clog2(STACK_DEPTH + 1);
    localparam int PW  = TYPE_W + ID_WIDTH;

    // piece stores, one write and one registered read each
    logic [PW-1:0] qmem [QUEUE_DEPTH];
    logic [PW-1:0] smem [STACK_DEPTH];

    logic [QA-1:0]       head_reg, head_next;
    logic [QA-1:0]       tail_reg, tail_next;
    logic [QCW-1:0]      qcount_reg, qcount_next;
    logic [SCW-1:0]      scount_reg, scount_next;
    logic [ID_WIDTH-1:0] id_reg, id_next;

    logic [KIND_W-1:0] kind_reg;
    logic [TYPE_W-1:0] type_reg;
    logic [QA-1:0]     q_ptr_reg;
    logic [SA-1:0]     s_ptr_reg;
    logic [PW-1:0]     q_rd_reg;
    logic [PW-1:0]     s_rd_reg;
    status_t           status_reg;
    logic              rep_valid_reg;
    logic [PW-1:0]     rep_reg;
    logic [M_TDATA_W-1:0] out_reg;

    logic          q_we, s_we;
    logic [QA-1:0] q_wa;
    logic [SA-1:0] s_wa;
    logic [PW-1:0] q_wd, s_wd;
    logic [PW-1:0] new_piece;
    logic          q_full, s_full;

    function automatic logic [QA-1:0] q_wrap(input logic [QA-1:0] p);
        return (p == QA'(QUEUE_DEPTH - 1)) ? '0 : p + QA'(1);
    endfunction

    assign new_piece = {type_reg, id_reg};
    assign q_full    = (qcount_reg == QCW'(QUEUE_DEPTH));
    assign s_full    = (scount_reg == SCW'(STACK_DEPTH));

    assign stat.kind    = kind_reg;
    assign stat.q_empty = (qcount_reg == '0);
    assign stat.s_empty = (scount_reg == '0);
    assign stat.q_lt3   = (qcount_reg < QCW'(TRIPLE));
    assign stat.s_lt3   = (scount_reg < SCW'(TRIPLE));

    // next pointers, counters and store writes per operation
    always_comb begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        qcount_next = qcount_reg;
        scount_next = scount_reg;
        id_next     = id_reg;
        q_we        = 1'b0;
        q_wa        = tail_reg;
        q_wd        = new_piece;
        s_we        = 1'b0;
        s_wa        = s_ptr_reg;
        s_wd        = q_rd_reg;
        case (cmd.op)
            OP_INSERT: begin
                // the id is used up even when the piece is dropped
                id_next = id_reg + ID_WIDTH'(1);
                if (!q_full) begin
                    q_we        = 1'b1;
                    tail_next   = q_wrap(tail_reg);
                    qcount_next = qcount_reg + QCW'(1);
                end
            end
            OP_PLAY: begin
                head_next = q_wrap(head_reg);
                tail_next = q_wrap(tail_reg);
                q_we      = 1'b1;
                id_next   = id_reg + ID_WIDTH'(1);
            end
            OP_RESERVE: begin
                head_next = q_wrap(head_reg);
                tail_next = q_wrap(tail_reg);
                q_we      = 1'b1;
                if (!s_full) begin
                    s_we        = 1'b1;
                    s_wa        = SA'(scount_reg);
                    scount_next = scount_reg + SCW'(1);
                    id_next     = id_reg + ID_WIDTH'(1);
                end else begin
                    // stack full: recycle the front piece to the rear
                    q_wd = q_rd_reg;
                end
            end
            OP_USE: begin
                scount_next = scount_reg - SCW'(1);
            end
            OP_SWAP: begin
                q_we = 1'b1;
                q_wa = q_ptr_reg;
                q_wd = s_rd_reg;
                s_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // store ports
    always_ff @(posedge aclk) begin
        if (q_we) begin
            qmem[q_wa] <= q_wd;
        end
        if (s_we) begin
            smem[s_wa] <= s_wd;
        end
        if (cmd.rd) begin
            q_rd_reg <= qmem[q_ptr_reg];
            s_rd_reg <= smem[s_ptr_reg];
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg   <= '0;
            tail_reg   <= '0;
            qcount_reg <= '0;
            scount_reg <= '0;
            id_reg     <= '0;
        end else begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            qcount_reg <= qcount_next;
            scount_reg <= scount_next;
            id_reg     <= id_next;
        end
    end

    // command fields, walk pointers and the reported piece
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            kind_reg      <= in_kind;
            type_reg      <= in_type;
            q_ptr_reg     <= head_reg;
            s_ptr_reg     <= SA'(scount_reg - SCW'(1));
            status_reg    <= STAT_OK;
            rep_valid_reg <= 1'b0;
            rep_reg       <= '0;
        end else begin
            if (cmd.step) begin
                q_ptr_reg <= q_wrap(q_ptr_reg);
                s_ptr_reg <= s_ptr_reg - SA'(1);
            end
            if (cmd.reject) begin
                status_reg <= cmd.code;
            end
            case (cmd.op)
                OP_INSERT: begin
                    if (q_full) begin
                        status_reg <= STAT_QFULL;
                    end
                end
                OP_PLAY: begin
                    rep_reg       <= q_rd_reg;
                    rep_valid_reg <= 1'b1;
                end
                OP_RESERVE: begin
                    if (!s_full) begin
                        rep_reg       <= q_rd_reg;
                        rep_valid_reg <= 1'b1;
                    end else begin
                        status_reg <= STAT_SFULL;
                    end
                end
                OP_USE: begin
                    rep_reg       <= s_rd_reg;
                    rep_valid_reg <= 1'b1;
                end
                default: begin
                end
            endcase
        end
        if (cmd.out_load) begin
            out_reg <= M_TDATA_W'({scount_reg, qcount_reg, rep_reg[ID_WIDTH-1:0],
                                   rep_reg[PW-1 -: TYPE_W], rep_valid_reg, status_reg});
        end
    end

    assign out_data = out_reg;

    `PQRS_ASSERT(a_qcount_range, aclk, aresetn, qcount_reg <= QCW'(QUEUE_DEPTH))
    `PQRS_ASSERT(a_scount_range, aclk, aresetn, scount_reg <= SCW'(STACK_DEPTH))
    `PQRS_ASSERT(a_empty_ptrs, aclk, aresetn, (qcount_reg == '0) |-> (head_reg == tail_reg))
    `PQRS_ASSERT(a_play_keeps_fill, aclk, aresetn, (cmd.op == OP_PLAY) |=> $stable(qcount_reg))
    `PQRS_ASSERT(a_insert_id, aclk, aresetn, (cmd.op == OP_INSERT) |=> (id_reg == ID_WIDTH'($past(id_reg) + 1'b1)))

endmodule

`default_nettype wire

>>> sv/piece_queue_with_reserve_stack.sv
// Top level of the piece queue with reserve stack
//
//  channel   dir  tdata                                         tuser
//  s_axis    in   [1:0] new_type                                [2:0] kind
//  m_axis    out  status, piece_valid, piece_type, piece_id,    -
//                 queue_fill, stack_fill (low bits up)
//
// One command at a time; each gives one result transaction.
// Insert and rejected commands go through check and done; play/reserve/use/swap
// one add a transfer state, and swap three a read and a transfer per pair: one
// queue and one stack port, so each swapped pair needs a read and a write.
// Reset clears pointers, fills and the id counter; store contents are not cleared.
// A stalled result holds in the output register; a finished command waits in the
// done state until the register frees up, then loads it and takes the next one.
`default_nettype none

module piece_queue_with_reserve_stack
    import pqrs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8,
    parameter int STACK_DEPTH = 3,
    parameter int ID_WIDTH    = 16,
    localparam int QCW        = $clog2(QUEUE_DEPTH + 1),
    localparam int SCW        = $clog2(STACK_DEPTH + 1),
    localparam int M_BITS     = STATUS_W + 1 + TYPE_W + ID_WIDTH + QCW + SCW,
    localparam int M_TDATA_W  = ((M_BITS + 7) / 8) * 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // [1:0] new_type
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    // [2:0] kind
    input  wire logic [S_TUSER_W-1:0] s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // status, piece_valid, piece_type, piece_id, queue_fill, stack_fill
    output logic [M_TDATA_W-1:0]      m_axis_tdata
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    pqrs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_ready (m_axis_tready),
        .m_valid (m_axis_tvalid),
        .stat    (stat),
        .cmd     (cmd)
    );

    pqrs_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .STACK_DEPTH (STACK_DEPTH),
        .ID_WIDTH    (ID_WIDTH),
        .M_TDATA_W   (M_TDATA_W)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_kind  (s_axis_tuser[KIND_W-1:0]),
        .in_type  (s_axis_tdata[TYPE_W-1:0]),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (m_axis_tdata)
    );

endmodule

`default_nettype wire

>>> tb/piece_queue_with_reserve_stack_test.sv
// Self-checking stream testbench for the piece queue with reserve stack
`timescale 1ns / 100ps
`default_nettype none

module piece_queue_with_reserve_stack_test;
    import pqrs_pkg::*;

    localparam int QDEPTH       = 8;
    localparam int SDEPTH       = 3;
    localparam int M_W          = 32;
    localparam int HALF_NS      = 6;
    // unused command codes, accepted and answered without any change
    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
    // inserts refused by a full queue that still use up ids
    localparam int FULL_INSERTS = 24;
    localparam int RANDOM_ITEMS = 1800;
    localparam int CALM_TAIL    = 150;
    localparam int HOLD_AT      = FULL_INSERTS + 420;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 24;
    localparam longint LIMIT_NS = 64'd48_000_000;

    // result field positions in m_axis_tdata
    localparam int ST_LO  = 0;
    localparam int PV_BIT = 3;
    localparam int PT_LO  = 4;
    localparam int PID_LO = 6;
    localparam int QF_LO  = 22;
    localparam int SF_LO  = 26;

    typedef struct packed {
        logic [TYPE_W-1:0] ptype;
        logic [15:0]       pid;
    } piece_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TYPE_W-1:0] ntype;
    } cmd_t;

    typedef struct {
        status_t           status;
        logic              valid;
        logic [TYPE_W-1:0] ptype;
        logic [15:0]       pid;
        logic [3:0]        qfill;
        logic [1:0]        sfill;
    } result_t;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [S_TUSER_W-1:0] s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_W-1:0]       m_axis_tdata;

    cmd_t    pending_cmds[$];
    result_t expected_results[$];

    // shadow state of the block
    piece_t      queue_mem[QDEPTH];
    piece_t      stack_mem[SDEPTH];
    int          q_head, q_tail, q_count, s_count;
    logic [15:0] id_next;

    int   errors      = 0;
    int   items_in    = 0;
    int   n_results   = 0;
    int   n_reports   = 0;
    int   status_hits[8];
    logic calm        = 1'b0;
    logic hold_done   = 1'b0;
    int   hold_left   = 0;
    int   gap_left    = 0;
    int   stall_left  = 0;

    piece_queue_with_reserve_stack u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 12 ns clock
    always begin
        #HALF_NS aclk = 1'b1;
        #HALF_NS aclk = 1'b0;
    end

    function automatic piece_t mint_piece(logic [TYPE_W-1:0] ntype);
        piece_t p;
        p.ptype = ntype;
        p.pid   = id_next;
        id_next = id_next + 16'd1;
        return p;
    endfunction

    function automatic void push_rear(piece_t p);
        queue_mem[q_tail] = p;
        q_tail  = (q_tail + 1 == QDEPTH) ? 0 : q_tail + 1;
        q_count = q_count + 1;
    endfunction

    function automatic piece_t take_front();
        piece_t p;
        p       = queue_mem[q_head];
        q_head  = (q_head + 1 == QDEPTH) ? 0 : q_head + 1;
        q_count = q_count - 1;
        return p;
    endfunction

    // Advance the shadow state by one command and return the result it gives
    function automatic result_t apply_command(logic [KIND_W-1:0] kind,
                                              logic [TYPE_W-1:0] ntype);
        result_t r;
        piece_t  p, t;
        int      qi, si;
        r.status = STAT_OK;
        r.valid  = 1'b0;
        r.ptype  = '0;
        r.pid    = '0;
        case (kind)
            KIND_INSERT: begin
                p = mint_piece(ntype);
                if (q_count == QDEPTH) r.status = STAT_QFULL;
                else push_rear(p);
            end
            KIND_PLAY: begin
                if (q_count == 0) begin
                    r.status = STAT_QEMPTY;
                end else begin
                    p       = take_front();
                    r.valid = 1'b1;
                    r.ptype = p.ptype;
                    r.pid   = p.pid;
                    push_rear(mint_piece(ntype));
                end
            end
            KIND_RESERVE: begin
                if (q_count == 0) begin
                    r.status = STAT_QEMPTY;
                end else begin
                    p = take_front();
                    if (s_count < SDEPTH) begin
                        stack_mem[s_count] = p;
                        s_count = s_count + 1;
                        r.valid = 1'b1;
                        r.ptype = p.ptype;
                        r.pid   = p.pid;
                        push_rear(mint_piece(ntype));
                    end else begin
                        // stack full: rotate the front to the rear
                        push_rear(p);
                        r.status = STAT_SFULL;
                    end
                end
            end
            KIND_USE: begin
                if (s_count == 0) begin
                    r.status = STAT_SEMPTY;
                end else begin
                    s_count = s_count - 1;
                    r.valid = 1'b1;
                    r.ptype = stack_mem[s_count].ptype;
                    r.pid   = stack_mem[s_count].pid;
                end
            end
            KIND_SWAP1: begin
                if (q_count == 0) begin
                    r.status = STAT_QEMPTY;
                end else if (s_count == 0) begin
                    r.status = STAT_SEMPTY;
                end else begin
                    t = queue_mem[q_head];
                    queue_mem[q_head] = stack_mem[s_count-1];
                    stack_mem[s_count-1] = t;
                end
            end
            KIND_SWAP3: begin
                if (q_count < TRIPLE || s_count < TRIPLE) begin
                    r.status = STAT_TRIPLE;
                end else begin
                    qi = q_head;
                    for (int i = 0; i < TRIPLE; i++) begin
                        si = s_count - 1 - i;
                        t = queue_mem[qi];
                        queue_mem[qi] = stack_mem[si];
                        stack_mem[si] = t;
                        qi = (qi + 1 == QDEPTH) ? 0 : qi + 1;
                    end
                end
            end
            default: ;
        endcase
        r.qfill = 4'(q_count);
        r.sfill = 2'(s_count);
        return r;
    endfunction

    function automatic void add_cmd(logic [KIND_W-1:0] kind, logic [TYPE_W-1:0] ntype);
        cmd_t c;
        c.kind  = kind;
        c.ntype = ntype;
        pending_cmds.push_back(c);
    endfunction

    // Pick a command kind; mode 0 grows the stack, 1 shrinks it, 2 is noise
    function automatic logic [KIND_W-1:0] pick_kind(int mode);
        int r;
        r = $urandom_range(0, 99);
        if (mode == 2) return KIND_W'($urandom_range(0, 7));
        if (mode == 0) begin
            if (r < 40) return KIND_RESERVE;
            if (r < 60) return KIND_SWAP3;
            if (r < 75) return KIND_SWAP1;
            if (r < 85) return KIND_PLAY;
            if (r < 90) return KIND_INSERT;
            return KIND_USE;
        end
        if (r < 40) return KIND_USE;
        if (r < 55) return KIND_SWAP1;
        if (r < 70) return KIND_PLAY;
        if (r < 80) return KIND_INSERT;
        if (r < 90) return KIND_RESERVE;
        return KIND_SWAP3;
    endfunction

    task automatic compare_field(string name, longint expv, longint actv);
        if (expv != actv) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
        end
    endtask

    // Drive commands: offer the next one once the current transaction completes
    always @(posedge aclk) begin : drive
        logic fire;
        cmd_t c;
        result_t r;
        fire = s_axis_tvalid && s_axis_tready;
        if (fire) begin
            r = apply_command(s_axis_tuser, s_axis_tdata[TYPE_W-1:0]);
            expected_results.push_back(r);
            items_in <= items_in + 1;
        end
        calm <= (pending_cmds.size() < CALM_TAIL);
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || fire) begin
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                gap_left = $urandom_range(0, 2);
                s_axis_tvalid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                c = pending_cmds.pop_front();
                s_axis_tuser  <= c.kind;
                s_axis_tdata  <= S_TDATA_W'(c.ntype);
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Count out the long receiver hold-off once, mid-run
    always @(posedge aclk) begin
        if (!hold_done && items_in >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Check each result transaction and pace the ready line
    always @(posedge aclk) begin : receive
        result_t e;
        if (m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: result with none expected, expected nothing, actual %h",
                         $time, m_axis_tdata);
            end else begin
                e = expected_results.pop_front();
                compare_field("status", e.status, m_axis_tdata[ST_LO +: STATUS_W]);
                compare_field("piece_valid", e.valid, m_axis_tdata[PV_BIT]);
                compare_field("piece_type", e.ptype, m_axis_tdata[PT_LO +: TYPE_W]);
                compare_field("piece_id", e.pid, m_axis_tdata[PID_LO +: 16]);
                compare_field("queue_fill", e.qfill, m_axis_tdata[QF_LO +: 4]);
                compare_field("stack_fill", e.sfill, m_axis_tdata[SF_LO +: 2]);
                n_results++;
                if (e.valid) n_reports++;
                status_hits[int'(e.status)]++;
            end
        end
        if (!aresetn || hold_left > 0) begin
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 2);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Build the command list, release reset, then wait for the drain
    initial begin
        int mode;
        q_head  = 0;
        q_tail  = 0;
        q_count = 0;
        s_count = 0;
        id_next = '0;
        foreach (status_hits[i]) status_hits[i] = 0;

        // empty queue and empty stack answers, plus the spare codes
        add_cmd(KIND_PLAY, 2'd0);
        add_cmd(KIND_RESERVE, 2'd1);
        add_cmd(KIND_USE, 2'd2);
        add_cmd(KIND_SWAP1, 2'd3);
        add_cmd(KIND_SWAP3, 2'd0);
        add_cmd(KIND_SPARE_LO, 2'd1);
        add_cmd(KIND_SPARE_HI, 2'd2);
        // fill the queue, then overflow it
        for (int i = 0; i <= QDEPTH; i++) add_cmd(KIND_INSERT, TYPE_W'(i));
        // keep inserting into the full queue; each refused piece still uses an id
        for (int i = 0; i < FULL_INSERTS; i++) add_cmd(KIND_INSERT, TYPE_W'($urandom_range(0, 3)));
        add_cmd(KIND_SWAP1, 2'd0);
        for (int i = 0; i < SDEPTH; i++) add_cmd(KIND_RESERVE, TYPE_W'(3 - i));
        add_cmd(KIND_RESERVE, 2'd2);
        add_cmd(KIND_SWAP1, 2'd1);
        add_cmd(KIND_SWAP3, 2'd2);
        add_cmd(KIND_PLAY, 2'd3);
        for (int i = 0; i <= SDEPTH; i++) add_cmd(KIND_USE, 2'd0);

        // random part in short runs of one flavor each
        mode = 0;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 16 == 0) begin
                mode = $urandom_range(0, 9);
                mode = (mode < 5) ? 0 : (mode < 9) ? 1 : 2;
            end
            add_cmd(pick_kind(mode), TYPE_W'($urandom_range(0, 3)));
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        do @(negedge aclk);
        while (pending_cmds.size() > 0 || s_axis_tvalid || expected_results.size() > 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Checked %0d commands (%0d piece reports, with full-queue refusals).",
                 n_results, n_reports);
        $display("Status counts ok/qfull/qempty/sfull/sempty/triple: %0d/%0d/%0d/%0d/%0d/%0d",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3],
                 status_hits[4], status_hits[5]);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Give up after a generous fixed time
    initial begin
        #(LIMIT_NS);
        $display("%0t: timeout, expected %0d more results, actual none",
                 $time, expected_results.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
